// ===== sv/hca_pkg.sv =====
package hca_pkg;

  localparam int MODE_W  = 3;
  localparam int CH_W    = 8;
  localparam int ALPHA_W = 13;
  localparam int AMT_W   = 16;
  localparam int HUE_W   = 15;
  localparam int PCT_W   = 15;

  // hue in 1/64 degree
  localparam logic [HUE_W-1:0] HUE_TURN       = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_HALF       = 15'd11520;
  localparam logic [HUE_W-1:0] HUE_THIRD      = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_SIXTH      = 15'd3840;

  // percentages in 1/256 percent
  localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;
  localparam logic [PCT_W-1:0] PCT_HALF = 15'd12800;

  // rgb to hsl dividers
  localparam int DIV_NUM_W  = 25;
  localparam int DIV_DEN_W  = 10;
  localparam int DIV_Q_W    = 15;
  localparam int DIV_STAGES = DIV_Q_W;

  // lightness: (sum * 2560 + 25) / 51 as a multiply by ceil(2^27 / 51) and a shift
  localparam logic [21:0] L_RECIP = 22'd2631721;

  // hsl to rgb output scaling: bias is 25600^2 * 3840
  localparam logic [51:0] CH_BIAS   = 52'd2516582400000;
  localparam logic [12:0] CH_RECIP  = 13'd7158;
  localparam logic [13:0] CH_DIVSOR = 14'd9375;

  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HUE_SHIFT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LIGHTEN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DARKEN     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SATURATE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DESATURATE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_GRAYSCALE  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_COMPLEMENT = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [CH_W-1:0]         red;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         blue;
    logic [ALPHA_W-1:0]      alpha;
    logic signed [AMT_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [ALPHA_W-1:0] out_alpha;
    logic [HUE_W-1:0]   hue_of_input;
    logic [PCT_W-1:0]   saturation_of_input;
    logic [PCT_W-1:0]   lightness_of_input;
  } result_t;

  typedef struct packed {
    item_t            item;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] light;
  } hsl_entry_t;

  typedef struct packed {
    logic       valid;
    hsl_entry_t data;
  } hsl_push_t;

endpackage

// ===== sv/hsl_colour_adjust.sv =====
// channel    | ports              | handshake
// -----------+--------------------+--------------------------------------------
// item in    | start, busy, item  | transaction when start is high, busy low
// result out | done, result       | done high for one cycle, cannot be held off
//
// one pixel per clock while busy is low; the time from the start edge to the edge
// ending done is set by the 15 stage dividers for hue and saturation (lightness by
// reciprocal, carried alongside) and the 8 stage hsl to rgb pipeline behind the queue
// rst is synchronous and clears valid flags, queue pointers and the queue count only
// the back end drains the queue every cycle, so busy never rises in practice
module hsl_colour_adjust (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hca_pkg::item_t   item,
  output logic             done,
  output hca_pkg::result_t result
);

  hca_pkg::hsl_push_t push;  // front end into the queue
  hca_pkg::hsl_push_t head;  // queue head, taken every cycle it is valid
  logic               full;
  logic               accept;

  // a transaction is taken whenever start is high and the queue has room
  assign accept = start & ~busy;
  assign busy   = full;

  // front end: min/max, delta, sum, two pipelined dividers, lightness by reciprocal
  hca_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .push   (push)
  );

  // short queue parting classification from reconstruction
  hca_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .head (head),
    .full (full)
  );

  // back end: apply mode, rebuild rgb by the css3 rule, round and clamp
  hca_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .result (result),
    .done   (done)
  );

endmodule

// ===== sv/hca_div.sv =====
module hca_div (
  input  logic                            clk,
  input  logic [hca_pkg::DIV_NUM_W-1:0]   num,
  input  logic [hca_pkg::DIV_DEN_W-1:0]   den,
  output logic [hca_pkg::DIV_Q_W-1:0]     quo
);

  // one quotient bit per stage, restoring
  logic [hca_pkg::DIV_NUM_W-1:0] rem [0:hca_pkg::DIV_Q_W-1];
  logic [hca_pkg::DIV_DEN_W-1:0] dv  [0:hca_pkg::DIV_Q_W-1];
  logic [hca_pkg::DIV_Q_W-1:0]   qa  [0:hca_pkg::DIV_Q_W];

  always_ff @(posedge clk) begin
    rem[0] <= num;
    dv[0]  <= den;
    qa[0]  <= '0;
  end

  genvar k;
  for (k = 0; k < hca_pkg::DIV_Q_W; k++) begin : g_stage
    localparam int SH = hca_pkg::DIV_Q_W - 1 - k;
    logic [hca_pkg::DIV_NUM_W-1:0] trial;
    logic                          fits;

    assign trial = hca_pkg::DIV_NUM_W'(dv[k]) << SH;
    assign fits  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      qa[k+1] <= qa[k] | (hca_pkg::DIV_Q_W'(fits) << SH);
    end

    if (k < hca_pkg::DIV_Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k+1] <= fits ? rem[k] - trial : rem[k];
        dv[k+1]  <= dv[k];
      end
    end
  end

  assign quo = qa[hca_pkg::DIV_Q_W];

endmodule

// ===== sv/hca_front.sv =====
module hca_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  hca_pkg::item_t     item,
  output hca_pkg::hsl_push_t push
);

  typedef struct packed {
    hca_pkg::item_t              item;
    logic                        grey;
    logic [hca_pkg::PCT_W-1:0]   light;
  } info_t;

  logic           v0;
  hca_pkg::item_t item_q;

  logic [7:0]  r, g, b, mx, mn, delta;
  logic [8:0]  sum, den_s;
  logic [11:0] t;
  logic        grey;

  logic [hca_pkg::DIV_NUM_W-1:0] num_h, num_s;
  logic [hca_pkg::DIV_DEN_W-1:0] den_h, den_s2;
  logic [hca_pkg::DIV_Q_W-1:0]   q_h, q_s;

  logic [20:0]               l_y;
  logic [42:0]               l_p;
  logic [hca_pkg::PCT_W-1:0] light_c;

  info_t                       info_pipe [0:hca_pkg::DIV_STAGES];
  logic [hca_pkg::DIV_STAGES:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      vpipe <= '0;
    end else begin
      v0    <= accept;
      vpipe <= {vpipe[hca_pkg::DIV_STAGES-1:0], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  always_comb begin
    r = item_q.red;
    g = item_q.green;
    b = item_q.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    den_s = (sum < 9'd255) ? sum : 9'd510 - sum;
    grey  = (delta == 8'd0);
    if (r == mx) begin
      if (g >= b) t = 12'(g) - 12'(b);
      else        t = 12'(delta) * 12'd6 + 12'(g) - 12'(b);
    end else if (g == mx) begin
      t = {3'b0, delta, 1'b0} + 12'(b) - 12'(r);
    end else begin
      t = {2'b0, delta, 2'b0} + 12'(r) - 12'(g);
    end
    // round half up: (2n + d) / 2d
    num_h  = 25'(t) * 25'd7680 + 25'(delta);
    den_h  = {1'b0, delta, 1'b0};
    num_s  = 25'(delta) * 25'd51200 + 25'(den_s);
    den_s2 = {den_s, 1'b0};
    // lightness rounded: (sum * 5120 + 51) / 102, halved then by reciprocal
    l_y     = 21'(sum) * 21'd2560 + 21'd25;
    l_p     = 43'(l_y) * 43'(hca_pkg::L_RECIP);
    light_c = l_p[41:27];
  end

  hca_div u_div_h (.clk(clk), .num(num_h), .den(den_h),  .quo(q_h));
  hca_div u_div_s (.clk(clk), .num(num_s), .den(den_s2), .quo(q_s));

  always_ff @(posedge clk) begin
    info_pipe[0] <= '{item: item_q, grey: grey, light: light_c};
    for (int k = 0; k < hca_pkg::DIV_STAGES; k++) begin
      info_pipe[k+1] <= info_pipe[k];
    end
  end

  always_comb begin
    push.valid      = vpipe[hca_pkg::DIV_STAGES];
    push.data.item  = info_pipe[hca_pkg::DIV_STAGES].item;
    push.data.light = info_pipe[hca_pkg::DIV_STAGES].light;
    if (info_pipe[hca_pkg::DIV_STAGES].grey) begin
      push.data.hue = '0;
      push.data.sat = '0;
    end else begin
      push.data.hue = (q_h == hca_pkg::HUE_TURN) ? '0 : q_h;
      push.data.sat = q_s;
    end
  end

endmodule

// ===== sv/hca_queue.sv =====
module hca_queue (
  input  logic               clk,
  input  logic               rst,
  input  hca_pkg::hsl_push_t push,
  output hca_pkg::hsl_push_t head,
  output logic               full
);

  hca_pkg::hsl_entry_t entries [0:1];
  logic                wp, rp;
  logic [1:0]          count;
  logic                pop;

  assign pop  = (count != 2'd0);
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push.valid) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push.valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wp] <= push.data;
    end
  end

  assign head.valid = pop;
  assign head.data  = entries[rp];

endmodule

// ===== sv/hca_back.sv =====
module hca_back (
  input  logic               clk,
  input  logic               rst,
  input  hca_pkg::hsl_push_t head,
  output hca_pkg::result_t   result,
  output logic               done
);

  function automatic logic [14:0] clamp_pct(input logic signed [17:0] x);
    logic [14:0] y;
    if (x < 18'sd0) y = '0;
    else if (x > 18'sd25600) y = hca_pkg::PCT_FULL;
    else y = x[14:0];
    return y;
  endfunction

  function automatic logic [14:0] wrap_hue(input logic signed [17:0] x);
    logic signed [17:0] y;
    if (x < -18'sd23040) y = x + 18'sd46080;
    else if (x < 18'sd0) y = x + 18'sd23040;
    else if (x < 18'sd23040) y = x;
    else if (x < 18'sd46080) y = x - 18'sd23040;
    else y = x - 18'sd46080;
    return y[14:0];
  endfunction

  function automatic logic [14:0] add_turn(input logic [14:0] h, input logic [14:0] off);
    logic [15:0] s;
    s = {1'b0, h} + {1'b0, off};
    if (s >= {1'b0, hca_pkg::HUE_TURN}) s = s - {1'b0, hca_pkg::HUE_TURN};
    return s[14:0];
  endfunction

  // channel ramp weight 0..3840
  function automatic logic [11:0] ramp(input logic [14:0] t);
    logic [11:0] f;
    if (t < hca_pkg::HUE_SIXTH) f = t[11:0];
    else if (t < 15'd11520) f = 12'd3840;
    else if (t < hca_pkg::HUE_TWO_THIRDS) f = 12'(hca_pkg::HUE_TWO_THIRDS - t);
    else f = '0;
    return f;
  endfunction

  hca_pkg::hsl_entry_t cp [1:7];
  logic [7:1]          v;

  // stage 1: adjustment
  logic signed [17:0] pct, hsum, lx, sx;
  logic [14:0]        hx;
  logic [14:0]        h1, s1, l1;

  always_comb begin
    pct  = head.data.item.amount[15] ? 18'sd0 :
           $signed({2'b0, head.data.item.amount});
    hsum = $signed({3'b0, head.data.hue}) +
           $signed({{2{head.data.item.amount[15]}}, head.data.item.amount});
    lx   = $signed({3'b0, head.data.light});
    sx   = $signed({3'b0, head.data.sat});
    hx   = head.data.hue;
    unique case (head.data.item.mode)
      hca_pkg::MODE_QUERY:      ;
      hca_pkg::MODE_HUE_SHIFT:  hx = wrap_hue(hsum);
      hca_pkg::MODE_LIGHTEN:    lx = lx + pct;
      hca_pkg::MODE_DARKEN:     lx = lx - pct;
      hca_pkg::MODE_SATURATE:   sx = sx + pct;
      hca_pkg::MODE_DESATURATE: sx = sx - pct;
      hca_pkg::MODE_GRAYSCALE:  sx = 18'sd0;
      hca_pkg::MODE_COMPLEMENT: hx = add_turn(head.data.hue, hca_pkg::HUE_HALF);
      default:                  ;
    endcase
  end

  always_ff @(posedge clk) begin
    h1 <= hx;
    s1 <= clamp_pct(sx);
    l1 <= clamp_pct(lx);
  end

  // stage 2: products and channel hue positions
  logic [29:0] ls2, lp2, sp2;
  logic        le2;
  logic [14:0] t2 [0:2];

  always_ff @(posedge clk) begin
    ls2   <= 30'(l1) * 30'(s1);
    lp2   <= 30'(l1) * 30'(hca_pkg::PCT_FULL);
    sp2   <= 30'(s1) * 30'(hca_pkg::PCT_FULL);
    le2   <= (l1 <= hca_pkg::PCT_HALF);
    t2[0] <= add_turn(h1, hca_pkg::HUE_THIRD);
    t2[1] <= h1;
    t2[2] <= add_turn(h1, hca_pkg::HUE_TWO_THIRDS);
  end

  // stage 3: m1, m2 and channel ramp weights
  logic [30:0] m2w;
  logic [29:0] m1_3, m2_3;
  logic [11:0] f3 [0:2];

  assign m2w = le2 ? 31'(ls2) + 31'(lp2) : 31'(lp2) + 31'(sp2) - 31'(ls2);

  always_ff @(posedge clk) begin
    m2_3 <= m2w[29:0];
    m1_3 <= 30'({lp2, 1'b0} - m2w);
    for (int c = 0; c < 3; c++) begin
      f3[c] <= ramp(t2[c]);
    end
  end

  // stage 4: ramp span and base
  logic [29:0] diff4;
  logic [41:0] base4;
  logic [11:0] f4 [0:2];

  always_ff @(posedge clk) begin
    diff4 <= m2_3 - m1_3;
    base4 <= 42'(m1_3) * 42'(hca_pkg::HUE_SIXTH);
    f4    <= f3;
  end

  // stage 5: per channel numerator
  logic [41:0] numer5 [0:2];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      numer5[c] <= base4 + 42'(diff4) * 42'(f4[c]);
    end
  end

  // stage 6: scale by 255 with rounding, drop power of two
  logic [51:0] y6 [0:2];
  logic [22:0] z6 [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      y6[c] = 52'(numer5[c]) * 52'd510 + hca_pkg::CH_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      z6[c] <= y6[c][51:29];
    end
  end

  // stage 7: reciprocal estimate of z / 9375
  logic [35:0] p7   [0:2];
  logic [9:0]  est7 [0:2];
  logic [22:0] z7   [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p7[c] = 36'(z6[c]) * 36'(hca_pkg::CH_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      est7[c] <= p7[c][35:26];
      z7[c]   <= z6[c];
    end
  end

  // stage 8: correction and clamp
  logic [23:0] rem8 [0:2];
  logic [9:0]  c8   [0:2];
  logic [7:0]  ch8  [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem8[c] = 24'(z7[c]) - 24'(est7[c]) * 24'(hca_pkg::CH_DIVSOR);
      c8[c]   = (rem8[c] >= 24'(hca_pkg::CH_DIVSOR)) ? est7[c] + 10'd1 : est7[c];
      ch8[c]  = (c8[c] > 10'd255) ? 8'd255 : c8[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    cp[1] <= head.data;
    for (int k = 2; k <= 7; k++) begin
      cp[k] <= cp[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[6:1], head.valid};
      done <= v[7];
    end
  end

  always_ff @(posedge clk) begin
    if (cp[7].item.mode == hca_pkg::MODE_QUERY) begin
      result.out_red   <= cp[7].item.red;
      result.out_green <= cp[7].item.green;
      result.out_blue  <= cp[7].item.blue;
    end else begin
      result.out_red   <= ch8[0];
      result.out_green <= ch8[1];
      result.out_blue  <= ch8[2];
    end
    result.out_alpha           <= cp[7].item.alpha;
    result.hue_of_input        <= cp[7].hue;
    result.saturation_of_input <= cp[7].sat;
    result.lightness_of_input  <= cp[7].light;
  end

endmodule
